/* rtl/yags_pkg.sv */
package yags_pkg;

    localparam int CHOICE_ENTRIES = 1024;
    localparam int CHOICE_IDX_W   = $clog2(CHOICE_ENTRIES);
    localparam int CACHE_ENTRIES  = 256;
    localparam int CACHE_IDX_W    = $clog2(CACHE_ENTRIES);
    localparam int CLEAR_ENTRIES  = (CHOICE_ENTRIES > CACHE_ENTRIES) ?
                                    CHOICE_ENTRIES : CACHE_ENTRIES;
    localparam int CLEAR_CNT_W    = $clog2(CLEAR_ENTRIES);

    localparam int TAG_W          = 8;
    localparam int CTR_W          = 2;
    localparam int CACHE_ENTRY_W  = TAG_W + CTR_W;
    localparam int HIST_W         = 16;
    localparam int HLEN_W         = 5;
    localparam int TWIDTH_W       = 4;
    localparam int CMD_W          = 3;
    localparam int PC_W           = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 5;
    localparam int SHIFT_W        = 6;

    localparam logic [CTR_W-1:0] CTR_WEAK_NT = 2'd1;
    localparam logic [CTR_W-1:0] CTR_WEAK_T  = 2'd2;

    localparam logic [HLEN_W-1:0]   HLEN_RESET   = 5'd8;
    localparam logic [HLEN_W-1:0]   HLEN_MAX     = 5'd16;
    localparam logic [TWIDTH_W-1:0] TWIDTH_RESET = 4'd8;
    localparam logic [TWIDTH_W-1:0] TWIDTH_MAX   = 4'd8;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOOKUP  = 3'd0,
        CMD_SPEC    = 3'd1,
        CMD_TRAIN   = 3'd2,
        CMD_RECOVER = 3'd3,
        CMD_FLUSH   = 3'd4
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_HIST_LEN  = 2'd0,
        CFG_XOR_MODE  = 2'd1,
        CFG_TAG_WIDTH = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic clear_en;
        logic capture;
        logic read_en;
        logic commit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

    function automatic logic [CTR_W-1:0] ctr_train(input logic [CTR_W-1:0] c,
                                                   input logic taken);
        logic [CTR_W-1:0] r;
        if (taken) begin
            r = (c == '1) ? c : c + 1'b1;
        end else begin
            r = (c == '0) ? c : c - 1'b1;
        end
        return r;
    endfunction

endpackage

/* rtl/yags_ram.sv */
module yags_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/yags_ctrl.sv */
module yags_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  yags_pkg::dp_status_t  status,
    output yags_pkg::ctrl_cmd_t   cmd
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_READ  = 4'b0100,
        ST_EXEC  = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_ready     = 1'b0;
        cmd         = '0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
                if (status.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
                if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.read_en = 1'b1;
                state_next  = ST_EXEC;
            end
            ST_EXEC: begin
                // hold until the output register can take the result
                if (status.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

endmodule

/* rtl/yags_dp.sv */
module yags_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  yags_pkg::ctrl_cmd_t                 cmd,
    output yags_pkg::dp_status_t                status,
    input  logic [yags_pkg::CMD_W-1:0]          s_cmd,
    input  logic [yags_pkg::PC_W-1:0]           s_pc,
    input  logic                                s_dir_bit,
    input  logic [yags_pkg::HIST_W-1:0]         s_snap_history,
    input  logic                                s_snap_choice,
    input  logic                                s_snap_pred,
    input  logic                                s_snap_hit,
    input  logic                                cfg_valid,
    input  logic [yags_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [yags_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_prediction,
    output logic                                m_choice_dir,
    output logic                                m_cache_hit,
    output logic [yags_pkg::HIST_W-1:0]         m_used_history
);

    localparam int CIW = yags_pkg::CHOICE_IDX_W;
    localparam int XIW = yags_pkg::CACHE_IDX_W;
    localparam int TW  = yags_pkg::TAG_W;
    localparam int CW  = yags_pkg::CTR_W;
    localparam int HW  = yags_pkg::HIST_W;
    localparam int EW  = yags_pkg::CACHE_ENTRY_W;
    localparam int PC_W_L = yags_pkg::PC_W;

    // configuration and history
    logic [yags_pkg::HLEN_W-1:0]   hist_len_reg;
    logic                          xor_mode_reg;
    logic [yags_pkg::TWIDTH_W-1:0] tag_len_reg;
    logic [HW-1:0]                 history_reg, history_next;
    logic [yags_pkg::CLEAR_CNT_W-1:0] clr_cnt_reg;

    // captured transaction
    logic [yags_pkg::CMD_W-1:0] cmd_reg;
    logic [yags_pkg::PC_W-1:0]  pc_reg;
    logic                       dir_reg;
    logic [HW-1:0]              snap_hist_reg;
    logic                       snap_choice_reg;
    logic                       snap_pred_reg;
    logic                       snap_hit_reg;

    // output register
    logic          m_valid_reg, m_valid_next;
    logic          pred_reg, choice_reg, hit_reg;
    logic [HW-1:0] used_hist_reg;

    // memories
    logic           c_we, t_we, nt_we;
    logic [CIW-1:0] c_addr;
    logic [XIW-1:0] x_waddr;
    logic [CW-1:0]  c_wdata, c_rdata;
    logic [EW-1:0]  t_wdata, nt_wdata, t_rdata, nt_rdata;

    // index and tag
    logic [yags_pkg::HLEN_W-1:0]   hl;
    logic [yags_pkg::TWIDTH_W-1:0] tw;
    logic [yags_pkg::SHIFT_W-1:0]  sh;
    logic [HW-1:0]                 hist_sel, hmask;
    logic [PC_W_L-1:0]             hist_shift;
    logic [XIW-1:0]                cache_ix;
    logic [TW-1:0]                 tag_keep, pc_tag;

    // execute
    logic           is_lookup, is_train;
    logic           choice_bit, lk_hit, lk_pred;
    logic [EW-1:0]  lk_ent, tr_ent, tr_new;
    logic [CW-1:0]  tr_ctr;
    logic           tr_upd, choice_upd;

    assign hl = (hist_len_reg > yags_pkg::HLEN_MAX) ? yags_pkg::HLEN_MAX : hist_len_reg;
    assign tw = (tag_len_reg > yags_pkg::TWIDTH_MAX) ? yags_pkg::TWIDTH_MAX
                                                      : tag_len_reg;
    assign hmask    = HW'(((HW+1)'(1) << hl) - (HW+1)'(1));
    assign tag_keep = TW'(((TW+1)'(1) << tw) - (TW+1)'(1));
    assign pc_tag   = pc_reg[TW-1:0] & tag_keep;

    assign is_lookup = (cmd_reg == yags_pkg::CMD_LOOKUP);
    assign is_train  = (cmd_reg == yags_pkg::CMD_TRAIN);
    assign hist_sel  = is_lookup ? history_reg : snap_hist_reg;

    always_comb begin
        sh = '0;
        if (yags_pkg::SHIFT_W'(XIW) > yags_pkg::SHIFT_W'(hl)) begin
            sh = yags_pkg::SHIFT_W'(XIW) - yags_pkg::SHIFT_W'(hl);
        end
        hist_shift = PC_W_L'(hist_sel) << sh;
        if (xor_mode_reg) begin
            cache_ix = pc_reg[XIW-1:0] ^ hist_shift[XIW-1:0];
        end else begin
            cache_ix = (pc_reg[XIW-1:0] << hl) | XIW'(hist_sel);
        end
    end

    // lookup
    assign choice_bit = c_rdata[CW-1];
    assign lk_ent     = choice_bit ? nt_rdata : t_rdata;
    assign lk_hit     = (lk_ent[EW-1:CW] == pc_tag);
    assign lk_pred    = lk_hit ? lk_ent[CW-1] : choice_bit;

    // train
    assign tr_ent     = snap_choice_reg ? nt_rdata : t_rdata;
    assign tr_ctr     = yags_pkg::ctr_train(tr_ent[CW-1:0], dir_reg);
    assign tr_upd     = snap_hit_reg | (snap_choice_reg ^ dir_reg);
    assign tr_new     = {(snap_hit_reg ? tr_ent[EW-1:CW] : pc_tag), tr_ctr};
    assign choice_upd = !((snap_pred_reg == dir_reg) && (snap_choice_reg != dir_reg));

    always_comb begin
        if (cmd.clear_en) begin
            c_we     = 1'b1;
            t_we     = 1'b1;
            nt_we    = 1'b1;
            c_addr   = clr_cnt_reg[CIW-1:0];
            x_waddr  = clr_cnt_reg[XIW-1:0];
            c_wdata  = clr_cnt_reg[0] ? yags_pkg::CTR_WEAK_T : yags_pkg::CTR_WEAK_NT;
            t_wdata  = {TW'(0), yags_pkg::CTR_WEAK_T};
            nt_wdata = {TW'(0), yags_pkg::CTR_WEAK_NT};
        end else begin
            c_we     = cmd.commit & is_train & choice_upd;
            t_we     = cmd.commit & is_train & tr_upd & !snap_choice_reg;
            nt_we    = cmd.commit & is_train & tr_upd & snap_choice_reg;
            c_addr   = pc_reg[CIW-1:0];
            x_waddr  = cache_ix;
            c_wdata  = yags_pkg::ctr_train(c_rdata, dir_reg);
            t_wdata  = tr_new;
            nt_wdata = tr_new;
        end
    end

    yags_ram #(.WIDTH(CW), .DEPTH(yags_pkg::CHOICE_ENTRIES)) u_choice_ram (
        .aclk  (aclk),
        .we    (c_we),
        .waddr (c_addr),
        .wdata (c_wdata),
        .re    (cmd.read_en),
        .raddr (pc_reg[CIW-1:0]),
        .rdata (c_rdata)
    );

    yags_ram #(.WIDTH(EW), .DEPTH(yags_pkg::CACHE_ENTRIES)) u_taken_ram (
        .aclk  (aclk),
        .we    (t_we),
        .waddr (x_waddr),
        .wdata (t_wdata),
        .re    (cmd.read_en),
        .raddr (cache_ix),
        .rdata (t_rdata)
    );

    yags_ram #(.WIDTH(EW), .DEPTH(yags_pkg::CACHE_ENTRIES)) u_not_taken_ram (
        .aclk  (aclk),
        .we    (nt_we),
        .waddr (x_waddr),
        .wdata (nt_wdata),
        .re    (cmd.read_en),
        .raddr (cache_ix),
        .rdata (nt_rdata)
    );

    always_comb begin
        history_next = history_reg;
        if (cmd.commit) begin
            case (cmd_reg)
                yags_pkg::CMD_SPEC:    history_next = {history_reg[HW-2:0], dir_reg} & hmask;
                yags_pkg::CMD_RECOVER: history_next = {snap_hist_reg[HW-2:0], dir_reg} & hmask;
                yags_pkg::CMD_FLUSH:   history_next = snap_hist_reg;
                default:               history_next = history_reg;
            endcase
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hist_len_reg  <= yags_pkg::HLEN_RESET;
            xor_mode_reg  <= 1'b1;
            tag_len_reg   <= yags_pkg::TWIDTH_RESET;
            history_reg   <= '0;
            clr_cnt_reg   <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                if (cfg_index == yags_pkg::CFG_HIST_LEN) begin
                    hist_len_reg <= cfg_data[yags_pkg::HLEN_W-1:0];
                end
                if (cfg_index == yags_pkg::CFG_XOR_MODE) begin
                    xor_mode_reg <= cfg_data[0];
                end
                if (cfg_index == yags_pkg::CFG_TAG_WIDTH) begin
                    tag_len_reg <= cfg_data[yags_pkg::TWIDTH_W-1:0];
                end
            end
            if (cmd.clear_en) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            end
            history_reg <= history_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            cmd_reg         <= s_cmd;
            pc_reg          <= s_pc;
            dir_reg         <= s_dir_bit;
            snap_hist_reg   <= s_snap_history;
            snap_choice_reg <= s_snap_choice;
            snap_pred_reg   <= s_snap_pred;
            snap_hit_reg    <= s_snap_hit;
        end
        if (cmd.commit) begin
            pred_reg      <= is_lookup & lk_pred;
            choice_reg    <= is_lookup & choice_bit;
            hit_reg       <= is_lookup & lk_hit;
            used_hist_reg <= is_lookup ? history_reg : '0;
        end
    end

    assign status.clear_last =
        (clr_cnt_reg == yags_pkg::CLEAR_CNT_W'(yags_pkg::CLEAR_ENTRIES - 1));
    assign status.out_free = !m_valid_reg || m_ready;

    assign m_valid        = m_valid_reg;
    assign m_prediction   = pred_reg;
    assign m_choice_dir   = choice_reg;
    assign m_cache_hit    = hit_reg;
    assign m_used_history = used_hist_reg;

endmodule

/* rtl/yags_branch_predictor.sv */
// Flow: an accepted transaction passes a table read state, then an execute and
// write-back state that registers the result; it may then wait for m_ready.
// No new transaction is accepted until the previous one has executed;
// execute holds while an earlier result still waits in the output register.
// Reset: synchronous, active low; afterwards a clearing pass initialises every
// entry of the choice table and both direction caches before s_ready rises.
module yags_branch_predictor (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [yags_pkg::CMD_W-1:0]       s_cmd,
    input  logic [yags_pkg::PC_W-1:0]        s_pc,
    input  logic                             s_dir_bit,
    input  logic [yags_pkg::HIST_W-1:0]      s_snap_history,
    input  logic                             s_snap_choice,
    input  logic                             s_snap_pred,
    input  logic                             s_snap_hit,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_prediction,
    output logic                             m_choice_dir,
    output logic                             m_cache_hit,
    output logic [yags_pkg::HIST_W-1:0]      m_used_history,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [yags_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [yags_pkg::CFG_DATA_W-1:0]  cfg_data
);

    yags_pkg::ctrl_cmd_t  ctrl_cmd;
    yags_pkg::dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    yags_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    yags_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (ctrl_cmd),
        .status         (dp_status),
        .s_cmd          (s_cmd),
        .s_pc           (s_pc),
        .s_dir_bit      (s_dir_bit),
        .s_snap_history (s_snap_history),
        .s_snap_choice  (s_snap_choice),
        .s_snap_pred    (s_snap_pred),
        .s_snap_hit     (s_snap_hit),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_prediction   (m_prediction),
        .m_choice_dir   (m_choice_dir),
        .m_cache_hit    (m_cache_hit),
        .m_used_history (m_used_history)
    );

    // one transaction in flight: no second acceptance straight after the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while a transaction is in flight");

    // each accepted transaction must lead to a result on m_valid
    a_result_due: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##3 m_valid)
        else $error("result missing after accepted transaction");

    // the clearing pass keeps the input closed straight after reset
    a_clear_after_reset: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(aresetn) |-> !s_ready)
        else $error("input open before table clearing finished");

    // commit only happens when the output register can take the result
    a_commit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_cmd.commit |-> dp_status.out_free)
        else $error("result committed over a pending result");

endmodule

/* bench/tb_yags_branch_predictor.sv */
`timescale 1ns / 1ps

module tb_yags_branch_predictor;

    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned PHASES      = 8;
    localparam int unsigned PHASE_ITEMS = 100;
    localparam int unsigned POOL_SIZE   = 16;

    // Reserved command codes: they change no state but still return a zero result
    localparam logic [yags_pkg::CMD_W-1:0] CMD_RSVD_A = 3'd5;
    localparam logic [yags_pkg::CMD_W-1:0] CMD_RSVD_B = 3'd6;
    localparam logic [yags_pkg::CMD_W-1:0] CMD_RSVD_C = 3'd7;

    typedef struct packed {
        logic                        pred;
        logic                        choice;
        logic                        hit;
        logic [yags_pkg::HIST_W-1:0] hist;
    } pred_result_t;

    class direction_scoreboard;
        logic [yags_pkg::CTR_W-1:0]    choice_ctr [yags_pkg::CHOICE_ENTRIES];
        logic [yags_pkg::TAG_W-1:0]    tkn_tag    [yags_pkg::CACHE_ENTRIES];
        logic [yags_pkg::CTR_W-1:0]    tkn_ctr    [yags_pkg::CACHE_ENTRIES];
        logic [yags_pkg::TAG_W-1:0]    ntk_tag    [yags_pkg::CACHE_ENTRIES];
        logic [yags_pkg::CTR_W-1:0]    ntk_ctr    [yags_pkg::CACHE_ENTRIES];
        logic [yags_pkg::HIST_W-1:0]   ghist;
        logic [yags_pkg::HLEN_W-1:0]   hist_len;
        logic                          xor_mode;
        logic [yags_pkg::TWIDTH_W-1:0] tag_len;
        pred_result_t                  owed_predictions [$];
        int unsigned                   mismatches;

        function new();
            for (int i = 0; i < yags_pkg::CHOICE_ENTRIES; i++) begin
                choice_ctr[i] = (i % 2 == 1) ? yags_pkg::CTR_WEAK_T : yags_pkg::CTR_WEAK_NT;
            end
            for (int i = 0; i < yags_pkg::CACHE_ENTRIES; i++) begin
                tkn_tag[i] = '0;
                tkn_ctr[i] = yags_pkg::CTR_WEAK_T;
                ntk_tag[i] = '0;
                ntk_ctr[i] = yags_pkg::CTR_WEAK_NT;
            end
            ghist      = '0;
            hist_len   = yags_pkg::HLEN_RESET;
            xor_mode   = 1'b1;
            tag_len    = yags_pkg::TWIDTH_RESET;
            mismatches = 0;
        endfunction

        function void set_register(yags_pkg::cfg_idx_t idx,
                                   logic [yags_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                yags_pkg::CFG_HIST_LEN:  hist_len = data[yags_pkg::HLEN_W-1:0];
                yags_pkg::CFG_XOR_MODE:  xor_mode = data[0];
                yags_pkg::CFG_TAG_WIDTH: tag_len  = data[yags_pkg::TWIDTH_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned hist_span();
            return (hist_len > yags_pkg::HLEN_MAX) ? yags_pkg::HLEN_MAX : hist_len;
        endfunction

        function logic [yags_pkg::CTR_W-1:0] saturate_step(logic [yags_pkg::CTR_W-1:0] c,
                                                           logic taken);
            if (taken) begin
                return (c == '1) ? c : c + 1'b1;
            end
            return (c == '0) ? c : c - 1'b1;
        endfunction

        function logic [yags_pkg::TAG_W-1:0] tag_bits(logic [yags_pkg::PC_W-1:0] pc);
            int unsigned w;
            logic [63:0] m;
            w = (tag_len > yags_pkg::TWIDTH_MAX) ? yags_pkg::TWIDTH_MAX : tag_len;
            m = (64'd1 << w) - 64'd1;
            return pc[yags_pkg::TAG_W-1:0] & m[yags_pkg::TAG_W-1:0];
        endfunction

        function logic [yags_pkg::CACHE_IDX_W-1:0] cache_slot(
                logic [yags_pkg::PC_W-1:0] pc, logic [yags_pkg::HIST_W-1:0] h);
            int unsigned hl;
            int unsigned sh;
            logic [63:0] v;
            hl = hist_span();
            if (xor_mode) begin
                // shorter histories sit higher so they reach the top index bits
                sh = (yags_pkg::CACHE_IDX_W > hl) ? yags_pkg::CACHE_IDX_W - hl : 0;
                v  = {32'd0, pc} ^ ({48'd0, h} << sh);
            end else begin
                v = ({32'd0, pc} << hl) | {48'd0, h};
            end
            return v[yags_pkg::CACHE_IDX_W-1:0];
        endfunction

        function pred_result_t note_command(logic [yags_pkg::CMD_W-1:0] cmd,
                                            logic [yags_pkg::PC_W-1:0] pc, logic dir,
                                            logic [yags_pkg::HIST_W-1:0] shist,
                                            logic schoice, logic spred, logic shit);
            pred_result_t r;
            logic [yags_pkg::CACHE_IDX_W-1:0] slot;
            logic [yags_pkg::CHOICE_IDX_W-1:0] ci;
            logic [yags_pkg::TAG_W-1:0] tag;
            logic [yags_pkg::CTR_W-1:0] ctr;
            logic [63:0] m;
            logic [63:0] v;
            r  = '0;
            ci = pc[yags_pkg::CHOICE_IDX_W-1:0];
            m  = (64'd1 << hist_span()) - 64'd1;
            case (cmd)
                yags_pkg::CMD_LOOKUP: begin
                    slot     = cache_slot(pc, ghist);
                    r.hist   = ghist;
                    r.choice = choice_ctr[ci][1];
                    tag      = r.choice ? ntk_tag[slot] : tkn_tag[slot];
                    ctr      = r.choice ? ntk_ctr[slot] : tkn_ctr[slot];
                    r.hit    = (tag == tag_bits(pc));
                    r.pred   = r.hit ? ctr[1] : r.choice;
                end
                yags_pkg::CMD_SPEC: begin
                    v     = (({48'd0, ghist} << 1) | {63'd0, dir}) & m;
                    ghist = v[yags_pkg::HIST_W-1:0];
                end
                yags_pkg::CMD_TRAIN: begin
                    slot = cache_slot(pc, shist);
                    if (shit || (schoice != dir)) begin
                        if (schoice) ntk_ctr[slot] = saturate_step(ntk_ctr[slot], dir);
                        else         tkn_ctr[slot] = saturate_step(tkn_ctr[slot], dir);
                    end
                    // allocate on a miss that went against the choice
                    if (!shit && (schoice != dir)) begin
                        if (schoice) ntk_tag[slot] = tag_bits(pc);
                        else         tkn_tag[slot] = tag_bits(pc);
                    end
                    if (!(spred == dir && schoice != dir)) begin
                        choice_ctr[ci] = saturate_step(choice_ctr[ci], dir);
                    end
                end
                yags_pkg::CMD_RECOVER: begin
                    v     = (({48'd0, shist} << 1) | {63'd0, dir}) & m;
                    ghist = v[yags_pkg::HIST_W-1:0];
                end
                yags_pkg::CMD_FLUSH: ghist = shist;
                default: ;
            endcase
            owed_predictions.push_back(r);
            return r;
        endfunction

        function void check_result(pred_result_t got);
            pred_result_t want;
            if (owed_predictions.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected result: pred=%0d choice=%0d hit=%0d hist=%h",
                             got.pred, got.choice, got.hit, got.hist);
                end
                return;
            end
            want = owed_predictions.pop_front();
            if (got.pred !== want.pred || got.choice !== want.choice ||
                got.hit !== want.hit || got.hist !== want.hist) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch: expected pred=%0d choice=%0d hit=%0d hist=%h",
                             want.pred, want.choice, want.hit, want.hist);
                    $display("          got      pred=%0d choice=%0d hit=%0d hist=%h",
                             got.pred, got.choice, got.hit, got.hist);
                end
            end
        endfunction
    endclass

    logic                            aclk;
    logic                            aresetn        = 1'b0;
    logic                            s_valid        = 1'b0;
    logic                            s_ready;
    logic [yags_pkg::CMD_W-1:0]      s_cmd          = yags_pkg::CMD_LOOKUP;
    logic [yags_pkg::PC_W-1:0]       s_pc           = '0;
    logic                            s_dir_bit      = 1'b0;
    logic [yags_pkg::HIST_W-1:0]     s_snap_history = '0;
    logic                            s_snap_choice  = 1'b0;
    logic                            s_snap_pred    = 1'b0;
    logic                            s_snap_hit     = 1'b0;
    logic                            m_valid;
    logic                            m_ready        = 1'b0;
    logic                            m_prediction;
    logic                            m_choice_dir;
    logic                            m_cache_hit;
    logic [yags_pkg::HIST_W-1:0]     m_used_history;
    logic                            cfg_valid      = 1'b0;
    logic                            cfg_ready;
    logic [yags_pkg::CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [yags_pkg::CFG_DATA_W-1:0] cfg_data       = '0;

    direction_scoreboard       sb;
    bit                        steady_flow = 1'b1;
    int unsigned               items_sent  = 0;
    logic [yags_pkg::PC_W-1:0] pc_pool [POOL_SIZE];
    logic                      pc_bias [POOL_SIZE];

    int unsigned hl_plan [PHASES] = '{0, 16, 31, 3, 12, 1, 20, 8};
    int unsigned xm_plan [PHASES] = '{1, 0, 1, 0, 1, 0, 0, 1};
    int unsigned tw_plan [PHASES] = '{0, 1, 15, 8, 4, 7, 0, 9};

    yags_branch_predictor DUT (.*);

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic logic coin();
        return 1'($urandom_range(0, 1));
    endfunction

    task automatic send_command(input logic [yags_pkg::CMD_W-1:0] cmd,
                                input logic [yags_pkg::PC_W-1:0] pc, input logic dir,
                                input logic [yags_pkg::HIST_W-1:0] shist,
                                input logic schoice, input logic spred, input logic shit,
                                output pred_result_t seen);
        int unsigned gap;
        gap = steady_flow ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_cmd          <= cmd;
        s_pc           <= pc;
        s_dir_bit      <= dir;
        s_snap_history <= shist;
        s_snap_choice  <= schoice;
        s_snap_pred    <= spred;
        s_snap_hit     <= shit;
        do @(posedge aclk); while (!s_ready);
        seen = sb.note_command(cmd, pc, dir, shist, schoice, spred, shit);
        if (cmd <= yags_pkg::CMD_FLUSH) items_sent++;
    endtask

    task automatic send_noise();
        pred_result_t dummy;
        send_command(yags_pkg::CMD_W'($urandom_range(0, 7)), $urandom(), coin(),
                     yags_pkg::HIST_W'($urandom()), coin(), coin(), coin(), dummy);
    endtask

    task automatic write_reg(input yags_pkg::cfg_idx_t idx,
                             input logic [yags_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_register(idx, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Hold the sender until every owed result has come back
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.owed_predictions.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Lookup, maybe spec shift, train on snapshot, maybe repair mispredict or flush
    task automatic run_branch(input logic [yags_pkg::PC_W-1:0] pc, input logic bias);
        pred_result_t look;
        pred_result_t dummy;
        logic outcome;
        send_command(yags_pkg::CMD_LOOKUP, pc, coin(), yags_pkg::HIST_W'($urandom()),
                     coin(), coin(), coin(), look);
        if ($urandom_range(0, 3) != 0) begin
            send_command(yags_pkg::CMD_SPEC, pc, look.pred, yags_pkg::HIST_W'($urandom()),
                         coin(), coin(), coin(), dummy);
        end
        outcome = ($urandom_range(0, 4) != 0) ? bias : ~bias;
        send_command(yags_pkg::CMD_TRAIN, pc, outcome, look.hist, look.choice, look.pred,
                     look.hit, dummy);
        if (outcome != look.pred && $urandom_range(0, 3) != 0) begin
            send_command(yags_pkg::CMD_RECOVER, pc, outcome, look.hist, coin(), coin(),
                         coin(), dummy);
        end else if ($urandom_range(0, 15) == 0) begin
            send_command(yags_pkg::CMD_FLUSH, pc, coin(), look.hist, coin(), coin(),
                         coin(), dummy);
        end
    endtask

    initial begin : result_sink
        int unsigned stall;
        pred_result_t got;
        @(posedge aclk);
        forever begin
            stall = steady_flow ? 0 : $urandom_range(0, 10);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            got.pred   = m_prediction;
            got.choice = m_choice_dir;
            got.hit    = m_cache_hit;
            got.hist   = m_used_history;
            sb.check_result(got);
        end
    end

    initial begin : watchdog
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        pred_result_t r;
        pred_result_t dummy;
        int unsigned phase_start;
        int unsigned pick;
        sb = new();
        for (int i = 0; i < POOL_SIZE; i++) begin
            pc_pool[i] = $urandom();
            pc_bias[i] = coin();
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed checks at the reset settings, no idling
        send_command(yags_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, r);
        send_command(yags_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,
                     1'b1, 1'b1, 1'b1, r);
        send_command(yags_pkg::CMD_SPEC, 32'h0000_0000, 1'b1, 16'h0000,
                     1'b0, 1'b0, 1'b0, dummy);
        send_command(yags_pkg::CMD_SPEC, 32'h0000_0000, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, dummy);
        send_command(yags_pkg::CMD_LOOKUP, 32'h0000_1235, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, r);
        send_command(yags_pkg::CMD_TRAIN, 32'h0000_1235, ~r.pred, r.hist,
                     r.choice, r.pred, r.hit, dummy);
        send_command(yags_pkg::CMD_TRAIN, 32'h0000_1235, 1'b1, r.hist,
                     r.choice, r.pred, 1'b1, dummy);
        send_command(yags_pkg::CMD_TRAIN, 32'h0000_4321, 1'b0, 16'h0012,
                     1'b1, 1'b1, 1'b0, dummy);
        send_command(yags_pkg::CMD_TRAIN, 32'h0000_4321, 1'b1, 16'h0012,
                     1'b0, 1'b1, 1'b0, dummy);
        send_command(yags_pkg::CMD_RECOVER, 32'h0000_0000, 1'b1, 16'hFFFF,
                     1'b0, 1'b0, 1'b0, dummy);
        send_command(yags_pkg::CMD_LOOKUP, 32'hA5A5_A5A5, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, r);
        send_command(yags_pkg::CMD_FLUSH, 32'h0000_0000, 1'b0, 16'hFFFF,
                     1'b0, 1'b0, 1'b0, dummy);
        send_command(yags_pkg::CMD_LOOKUP, 32'h5A5A_5A5A, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, r);
        send_command(yags_pkg::CMD_SPEC, 32'h0000_0000, 1'b1, 16'h0000,
                     1'b0, 1'b0, 1'b0, dummy);
        send_command(CMD_RSVD_A, $urandom(), 1'b1, 16'hFFFF, 1'b1, 1'b1, 1'b1, dummy);
        send_command(CMD_RSVD_B, $urandom(), 1'b0, 16'h0000, 1'b0, 1'b0, 1'b0, dummy);
        send_command(CMD_RSVD_C, $urandom(), 1'b1, 16'hA5A5, 1'b0, 1'b1, 1'b0, dummy);
        send_command(yags_pkg::CMD_LOOKUP, 32'h8000_0001, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, r);
        send_command(yags_pkg::CMD_TRAIN, 32'hFFFF_FFFF, 1'b1, 16'hFFFF,
                     1'b1, 1'b1, 1'b1, dummy);
        send_command(yags_pkg::CMD_FLUSH, 32'h0000_0000, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, dummy);
        send_command(yags_pkg::CMD_LOOKUP, 32'h0000_0000, 1'b0, 16'h0000,
                     1'b0, 1'b0, 1'b0, r);
        settle();

        for (int p = 0; p < PHASES; p++) begin
            write_reg(yags_pkg::CFG_HIST_LEN, yags_pkg::CFG_DATA_W'(hl_plan[p]));
            write_reg(yags_pkg::CFG_XOR_MODE,
                      {4'($urandom_range(0, 15)), 1'(xm_plan[p])});
            write_reg(yags_pkg::CFG_TAG_WIDTH, {coin(), 4'(tw_plan[p])});
            steady_flow = ($urandom_range(0, 3) == 0);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) begin
                pick = $urandom_range(0, 99);
                if (pick < 80) begin
                    pick = $urandom_range(0, POOL_SIZE - 1);
                    run_branch(pc_pool[pick], pc_bias[pick]);
                end else if (pick < 94) begin
                    send_noise();
                end else if (pick < 97) begin
                    run_branch($urandom(), coin());
                end else begin
                    settle();
                end
            end
            settle();
        end

        repeat (10) @(posedge aclk);
        if (sb.mismatches == 0 && sb.owed_predictions.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
